// ----- hdl/pba_pkg.sv -----
// Shared types and constants for the page bitmap allocator.
// No dependencies; imported by page_bitmap_allocator and pba_word_div.
`default_nettype none
package pba_pkg;

  // page numbers, run lengths and sums of the two
  localparam int unsigned PCW     = 17;
  localparam int unsigned TALLY_W = 16;
  localparam int unsigned RADDR_W = 27;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_RESERVE = 2'd3;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_OOM       = 3'd1;
  localparam logic [2:0] STAT_BADADDR   = 3'd2;
  localparam logic [2:0] STAT_MARKED    = 3'd3;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd4;
  localparam logic [2:0] STAT_ZERO      = 3'd5;

  localparam logic REG_ACTIVE_PAGES = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_NEXT,
    ST_DIV,
    ST_RD,
    ST_CHK,
    ST_DONE
  } seq_state_e;

endpackage
`default_nettype wire

// ----- hdl/page_bitmap_allocator.sv -----
// Page bitmap allocator top: command sequencer, APB register, stream ports.
// Uses pba_pkg, pba_word_div and pba_map_ram.
// Zero size, bad address or oversized allocate: answered from decode, no map access;
//   a region command checks its pages word by word, then writes them in a second pass.
// Allocate: tries starts, stepped by the run length, from the hint to the active page count,
//   then from page 1 up to the hint; the first free run is written. One command at a time.
// Reset: a clearing pass sets every map word to all ones; no beats are accepted meanwhile.
`default_nettype none
module page_bitmap_allocator #(
  parameter int unsigned TOTAL_PAGES   = 32768,
  parameter int unsigned PAGE_BYTES    = 4096,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cmd[1:0], region_addr[49:2], size_bytes[81:50], zero fill
  input  wire logic [87:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // status[2:0], result_addr[29:3], used_count[45:30], zero fill
  output logic [47:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pba_pkg::*;

  localparam int unsigned PB_LOG    = $clog2(PAGE_BYTES);
  localparam int unsigned MAP_DEPTH = (TOTAL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned MAW       = $clog2(MAP_DEPTH);
  localparam int unsigned BIW       = $clog2(MAP_WORD_BITS);
  localparam int unsigned NW        = 33;

  seq_state_e state_q, state_d;

  logic [1:0]           cmd_q, cmd_d;
  logic [47:0]          pa_q, pa_d;
  logic [NW-1:0]        n_q, n_d;
  logic                 zero_q, zero_d;
  logic [PCW-1:0]       start_q, start_d, end_q, end_d, pg_q, pg_d, hint_q, hint_d;
  logic                 ph2_q, ph2_d, wpass_q, wpass_d;
  logic [MAW-1:0]       widx_q, widx_d;
  logic [BIW-1:0]       bidx_q, bidx_d;
  logic [TALLY_W-1:0]   tally_q, tally_d;
  logic [15:0]          active_q;
  logic [2:0]           stat_q, stat_d;
  logic [RADDR_W-1:0]   raddr_q, raddr_d;
  logic                 ovalid_q;
  logic [47:0]          odata_q;

  logic                 in_acc, cfg_wr, div_start, div_done;
  logic [PCW-1:0]       div_quo;
  logic [BIW-1:0]       div_rem;
  logic [15:0]          tot;
  logic [PCW-1:0]       tot_x, nn, lim, pg_nx;
  logic [47:0]          page_hi;
  logic                 bad, cand_out, cand_skip, target, cur_bit, hit, run_end, bwrap;
  logic                 underflow;
  logic [MAP_WORD_BITS-1:0] rdata, onehot, wdata;
  logic                 ram_we, ram_re;
  logic [MAW-1:0]       ram_waddr;
  logic [PCW:0]         tsum;
  logic [TALLY_W-1:0]   tally_sat;
  logic [63:0]          raddr_w;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_ACTIVE_PAGES) ? {16'd0, active_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 16'd32768;
    end else if (cfg_wr && paddr[2] == REG_ACTIVE_PAGES) begin
      active_q <= pwdata[15:0];
    end
  end

  // working limits
  assign tot     = (32'(active_q) > 32'(TOTAL_PAGES)) ? 16'(TOTAL_PAGES) : active_q;
  assign tot_x   = PCW'(tot);
  assign nn      = n_q[PCW-1:0];
  assign page_hi = pa_q >> PB_LOG;
  assign bad     = (|pa_q[PB_LOG-1:0]) || (page_hi >= 48'(tot))
                || ((49'(page_hi) + 49'(n_q)) > 49'(tot));
  assign lim       = ph2_q ? hint_q : tot_x;
  assign cand_out  = start_q >= lim;
  assign cand_skip = (start_q >= tot_x) || (nn > (tot_x - start_q));
  assign target    = (cmd_q == CMD_ALLOC) || (cmd_q == CMD_RESERVE);
  assign cur_bit   = rdata[bidx_q];
  assign hit       = (cmd_q == CMD_ALLOC) ? cur_bit : (cur_bit == target);
  assign pg_nx     = pg_q + PCW'(1);
  assign run_end   = pg_nx == end_q;
  assign bwrap     = bidx_q == BIW'(MAP_WORD_BITS - 1);
  assign underflow = (cmd_q == CMD_FREE) && (nn > PCW'(tally_q));
  assign onehot    = MAP_WORD_BITS'(1) << bidx_q;
  assign wdata     = target ? (rdata | onehot) : (rdata & ~onehot);
  assign tsum      = (PCW+1)'(tally_q) + (PCW+1)'(nn);
  assign tally_sat = (tsum > (PCW+1)'({TALLY_W{1'b1}})) ? {TALLY_W{1'b1}} : tsum[TALLY_W-1:0];
  assign raddr_w   = 64'(start_q) << PB_LOG;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (widx_q == MAW'(MAP_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc) state_d = ST_DECODE;
      ST_DECODE: begin
        if (zero_q) state_d = ST_DONE;
        else if (cmd_q == CMD_ALLOC) state_d = (n_q > NW'(tot)) ? ST_DONE : ST_NEXT;
        else state_d = bad ? ST_DONE : ST_DIV;
      end
      ST_NEXT: begin
        if (cand_out) state_d = ph2_q ? ST_DONE : ST_NEXT;
        else if (cand_skip) state_d = ST_NEXT;
        else state_d = ST_DIV;
      end
      ST_DIV:    if (div_done) state_d = ST_RD;
      ST_RD:     state_d = ST_CHK;
      ST_CHK: begin
        if (!wpass_q && hit) state_d = (cmd_q == CMD_ALLOC) ? ST_NEXT : ST_DONE;
        else if (run_end) begin
          if (wpass_q || underflow) state_d = ST_DONE;
          else state_d = ST_DIV;
        end else state_d = bwrap ? ST_RD : ST_CHK;
      end
      ST_DONE:   if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cmd_d   = cmd_q;
    pa_d    = pa_q;
    n_d     = n_q;
    zero_d  = zero_q;
    start_d = start_q;
    end_d   = end_q;
    pg_d    = pg_q;
    hint_d  = hint_q;
    ph2_d   = ph2_q;
    wpass_d = wpass_q;
    widx_d  = widx_q;
    bidx_d  = bidx_q;
    tally_d = tally_q;
    stat_d  = stat_q;
    raddr_d = raddr_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    ram_waddr = widx_q;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        widx_d = widx_q + MAW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = s_axis_tdata[1:0];
          pa_d    = s_axis_tdata[49:2];
          n_d     = NW'(s_axis_tdata[81:50] >> PB_LOG)
                  + NW'(|s_axis_tdata[50 +: PB_LOG]);
          zero_d  = s_axis_tdata[81:50] == 32'd0;
          ph2_d   = 1'b0;
          wpass_d = 1'b0;
          stat_d  = STAT_OK;
          raddr_d = '0;
        end
      end
      ST_DECODE: begin
        if (zero_q) stat_d = STAT_ZERO;
        else if (cmd_q == CMD_ALLOC) begin
          if (n_q > NW'(tot)) stat_d = STAT_OOM;
          else start_d = hint_q;
        end else if (bad) stat_d = STAT_BADADDR;
        else begin
          start_d = PCW'(page_hi);
          pg_d    = PCW'(page_hi);
          end_d   = PCW'(page_hi) + nn;
        end
      end
      ST_NEXT: begin
        if (cand_out) begin
          if (ph2_q) stat_d = STAT_OOM;
          else begin
            ph2_d   = 1'b1;
            start_d = PCW'(1);
          end
        end else if (cand_skip) start_d = start_q + nn;
        else begin
          pg_d  = start_q;
          end_d = start_q + nn;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          widx_d = div_quo[MAW-1:0];
          bidx_d = div_rem;
        end
      end
      ST_RD: ram_re = 1'b1;
      ST_CHK: begin
        if (!wpass_q && hit) begin
          if (cmd_q == CMD_ALLOC) start_d = start_q + nn;
          else stat_d = STAT_MARKED;
        end else begin
          ram_we = wpass_q;
          if (run_end) begin
            if (wpass_q) begin
              if (cmd_q == CMD_ALLOC) begin
                tally_d = tally_sat;
                raddr_d = raddr_w[RADDR_W-1:0];
              end else if (cmd_q == CMD_FREE) begin
                tally_d = tally_q - TALLY_W'(nn);
                hint_d  = start_q;
              end else if (cmd_q == CMD_RESERVE) begin
                tally_d = tally_sat;
              end
            end else if (underflow) stat_d = STAT_UNDERFLOW;
            else begin
              wpass_d = 1'b1;
              pg_d    = start_q;
            end
          end else begin
            pg_d = pg_nx;
            if (bwrap) begin
              bidx_d = '0;
              widx_d = widx_q + MAW'(1);
            end else bidx_d = bidx_q + BIW'(1);
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign div_start = (state_q != ST_DIV) && (state_d == ST_DIV);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      widx_q   <= '0;
      tally_q  <= '0;
      hint_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      tally_q <= tally_d;
      hint_q  <= hint_d;
      if (state_q == ST_DONE && (!ovalid_q || m_axis_tready)) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    pa_q    <= pa_d;
    n_q     <= n_d;
    zero_q  <= zero_d;
    start_q <= start_d;
    end_q   <= end_d;
    pg_q    <= pg_d;
    ph2_q   <= ph2_d;
    wpass_q <= wpass_d;
    bidx_q  <= bidx_d;
    stat_q  <= stat_d;
    raddr_q <= raddr_d;
    if (state_q == ST_DONE && (!ovalid_q || m_axis_tready)) begin
      odata_q <= {2'b00, tally_q, raddr_q, stat_q};
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  pba_word_div #(
    .DIVISOR (MAP_WORD_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .value_i (pg_d),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  pba_map_ram #(
    .DEPTH (MAP_DEPTH),
    .WIDTH (MAP_WORD_BITS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((state_q == ST_CLEAR) ? {MAP_WORD_BITS{1'b1}} : wdata),
    .re_i    (ram_re),
    .raddr_i (widx_q),
    .rdata_o (rdata)
  );

  a_map_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_CLEAR || (state_q == ST_CHK && wpass_q)))
    else $error("map written outside clear or write pass");

  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_DECODE)
    else $error("accepted command not decoded");

  a_hint_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(hint_q) |-> $past(state_q == ST_CHK && cmd_q == CMD_FREE && wpass_q))
    else $error("hint moved outside a completed free");

  a_tally_only_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(tally_q) |-> $past(state_q == ST_CHK && wpass_q))
    else $error("tally moved outside a completed write pass");

endmodule
`default_nettype wire

// ----- hdl/pba_word_div.sv -----
// Page number split into map word index and bit index by shift and mask.
// Uses pba_pkg for the page number width; DIVISOR must be a power of two.
`default_nettype none
module pba_word_div #(
  parameter int unsigned DIVISOR = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [pba_pkg::PCW-1:0]           value_i,
  output logic                                   done_o,
  output logic [pba_pkg::PCW-1:0]                quo_o,
  output logic [$clog2(DIVISOR)-1:0]             rem_o
);
  import pba_pkg::*;

  localparam int unsigned RW = $clog2(DIVISOR);

  logic           done_q;
  logic [PCW-1:0] quo_q;
  logic [RW-1:0]  rem_q;

  // result is registered and ready in the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= value_i >> RW;
      rem_q <= value_i[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- hdl/pba_map_ram.sv -----
// Single-port-write, single-port-read page map memory, registered read.
// The read register also takes the written word so read-modify-write chains.
`default_nettype none
module pba_map_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end else if (we_i) begin
      rdata_q <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire
